[design/crs_pkg.sv]
package crs_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam int IN_TDATA_W  = 128;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 136;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int LVL_OUT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 16'd640;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 16'd480;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIT,
    ST_LOAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        w;
    logic [30:0]        h;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef struct packed {
    logic capture;
    logic edge_en;
    logic fit;
    logic pop_rd;
    logic load_top;
    logic clr;
    logic refuse;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       full;
    logic       lvl_zero;
  } stat_t;

endpackage

[design/clip_rect_stack.sv]
// Nested clip rectangle stack for a draw command stream.
// The input channel carries one command word: in_tuser selects push, pop or
// clear, and in_tdata holds the rectangle that a push intersects with the
// current top. Each word yields exactly one result word on the output channel
// with the current top rectangle, its empty flag, the depth and a flag for a
// push refused on a full stack.
// The screen size registers set the base entry and are written through the
// cfg port; the user must write them only while no command is in flight, as
// the block itself does not enforce it. A pop at the base, a clear and a
// refused push pass from the decode state to the done state; a push adds an
// edge stage in decode and a fit state, and a pop adds a load state that
// waits on the registered read of the stack memory. A new word is taken once
// the result is loaded, so none is accepted before the last one is through.
// Reset empties the stack, restores a 640 by 480 screen and drops out_tvalid.
// The result register holds its word while out_tready is low; a new input
// word is taken only when that register is free or drains in the same cycle.
module clip_rect_stack #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // rect_x, rect_y, rect_w, rect_h
  input  logic [crs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  logic [crs_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cur_x, cur_y, cur_w, cur_h, is_empty, level, push_refused, zero pad
  output logic [crs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic [crs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  crs_pkg::cmd_t  cmd;
  crs_pkg::stat_t stat;

  crs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  crs_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule

[design/crs_ram.sv]
module crs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[design/crs_ctrl.sv]
module crs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  crs_pkg::stat_t stat,
  output crs_pkg::cmd_t  cmd
);

  crs_pkg::state_t state_r;
  crs_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      crs_pkg::ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (in_tvalid && in_tready) begin
          cmd.capture = 1'b1;
          state_nxt   = crs_pkg::ST_DECODE;
        end
      end
      crs_pkg::ST_DECODE: begin
        state_nxt = crs_pkg::ST_DONE;
        case (stat.act)
          crs_pkg::ACT_PUSH: begin
            if (stat.full) begin
              cmd.refuse = 1'b1;
            end else begin
              cmd.edge_en = 1'b1;
              state_nxt   = crs_pkg::ST_FIT;
            end
          end
          crs_pkg::ACT_POP: begin
            if (!stat.lvl_zero) begin
              cmd.pop_rd = 1'b1;
              state_nxt  = crs_pkg::ST_LOAD;
            end
          end
          crs_pkg::ACT_CLEAR: begin
            cmd.clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      crs_pkg::ST_FIT: begin
        cmd.fit   = 1'b1;
        state_nxt = crs_pkg::ST_DONE;
      end
      crs_pkg::ST_LOAD: begin
        cmd.load_top = 1'b1;
        state_nxt    = crs_pkg::ST_DONE;
      end
      crs_pkg::ST_DONE: begin
        cmd.load_out  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = crs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = crs_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

[design/crs_dpath.sv]
module crs_dpath #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  crs_pkg::cmd_t                    cmd,
  output crs_pkg::stat_t                   stat,
  input  logic [crs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [crs_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                             cfg_we,
  input  logic [crs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [crs_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int LVL_W = $clog2(STACK_DEPTH);

  logic [crs_pkg::IN_TUSER_W-1:0]  act_r;
  logic signed [31:0]              req_x_r;
  logic signed [31:0]              req_y_r;
  logic signed [31:0]              req_w_r;
  logic signed [31:0]              req_h_r;
  logic [crs_pkg::CFG_DATA_W-1:0]  width_r;
  logic [crs_pkg::CFG_DATA_W-1:0]  height_r;
  logic [LVL_W-1:0]                level_r;
  crs_pkg::rect_t                  top_r;
  logic signed [31:0]              l_r;
  logic signed [31:0]              t_r;
  logic signed [33:0]              r_r;
  logic signed [33:0]              b_r;
  logic                            e_r;
  logic                            refused_r;
  logic [crs_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  crs_pkg::rect_t     base;
  crs_pkg::rect_t     cur;
  logic               base_e;
  logic               cur_e;
  logic               req_e;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic signed [33:0] ar;
  logic signed [33:0] br;
  logic signed [33:0] ab;
  logic signed [33:0] bb;
  logic signed [33:0] dw;
  logic signed [33:0] dh;
  logic               fit_e;
  crs_pkg::rect_t     res;
  crs_pkg::rect_t     ram_rdata;
  logic [LVL_W+3:0]   lvl_ext;

  always_comb begin
    base_e = (width_r == '0) || (height_r == '0);
    base   = '0;
    if (!base_e) begin
      base.w = {15'd0, width_r};
      base.h = {15'd0, height_r};
    end
    cur   = (level_r == '0) ? base : top_r;
    cur_x = cur.x;
    cur_y = cur.y;
    cur_e = (cur.w == '0) || (cur.h == '0);
    req_e = (req_w_r <= 32'sd0) || (req_h_r <= 32'sd0);
    ar = {{2{cur_x[31]}}, cur_x} + $signed({3'd0, cur.w});
    ab = {{2{cur_y[31]}}, cur_y} + $signed({3'd0, cur.h});
    br = {{2{req_x_r[31]}}, req_x_r} + {{2{req_w_r[31]}}, req_w_r};
    bb = {{2{req_y_r[31]}}, req_y_r} + {{2{req_h_r[31]}}, req_h_r};
    dw = r_r - {{2{l_r[31]}}, l_r};
    dh = b_r - {{2{t_r[31]}}, t_r};
    fit_e = e_r || (dw <= 34'sd0) || (dh <= 34'sd0);
    res = '0;
    if (!fit_e) begin
      res.x = l_r;
      res.y = t_r;
      res.w = dw[30:0];
      res.h = dh[30:0];
    end
    lvl_ext = {4'd0, level_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= crs_pkg::SCREEN_WIDTH_RST;
      height_r <= crs_pkg::SCREEN_HEIGHT_RST;
      level_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          crs_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_data;
          crs_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.fit) begin
        level_r <= level_r + LVL_W'(1);
      end else if (cmd.pop_rd) begin
        level_r <= level_r - LVL_W'(1);
      end else if (cmd.clr) begin
        level_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r     <= in_tuser;
      req_x_r   <= in_tdata[31:0];
      req_y_r   <= in_tdata[63:32];
      req_w_r   <= in_tdata[95:64];
      req_h_r   <= in_tdata[127:96];
      refused_r <= 1'b0;
    end else if (cmd.refuse) begin
      refused_r <= 1'b1;
    end
    if (cmd.edge_en) begin
      l_r <= (cur_x > req_x_r) ? cur_x : req_x_r;
      t_r <= (cur_y > req_y_r) ? cur_y : req_y_r;
      r_r <= (ar < br) ? ar : br;
      b_r <= (ab < bb) ? ab : bb;
      e_r <= cur_e || req_e;
    end
    if (cmd.fit) begin
      top_r <= res;
    end else if (cmd.load_top) begin
      top_r <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_tdata_r <= {4'd0, refused_r, lvl_ext[3:0], cur_e, cur.h, cur.w, cur.y, cur.x};
    end
  end

  crs_ram #(
    .WIDTH (crs_pkg::RECT_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (cmd.fit),
    .waddr   (level_r + LVL_W'(1)),
    .wdata   (res),
    .re      (cmd.pop_rd),
    .raddr   (level_r - LVL_W'(1)),
    .rdata_r (ram_rdata)
  );

  assign stat.act      = act_r;
  assign stat.full     = (level_r == LVL_W'(STACK_DEPTH - 1));
  assign stat.lvl_zero = (level_r == '0);
  assign out_tdata     = out_tdata_r;

endmodule

[design/crs_checker.sv]
module crs_checker #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [crs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [crs_pkg::LVL_OUT_W-1:0] FULL_LVL =
    crs_pkg::LVL_OUT_W'(STACK_DEPTH - 1);

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_empty_is_canonical: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[126] |->
      out_tdata[31:0] == '0 && out_tdata[63:32] == '0 &&
      out_tdata[94:64] == '0 && out_tdata[125:95] == '0)
    else $error("empty rectangle is not all zero");

  a_area_when_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[126] |-> out_tdata[94:64] != '0 && out_tdata[125:95] != '0)
    else $error("rectangle without area not flagged empty");

  a_refused_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[131] |-> out_tdata[130:127] == FULL_LVL)
    else $error("push refused below full depth");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

endmodule

bind clip_rect_stack crs_checker #(.STACK_DEPTH(STACK_DEPTH)) u_crs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
